@@ rtl/cmc_pkg.sv @@
// Shared constants, types and action codes for the confusion matrix counter.
package cmc_pkg;

    localparam int LABEL_COUNT = 16;
    localparam int LABEL_BITS  = $clog2(LABEL_COUNT);
    localparam int CELL_COUNT  = LABEL_COUNT * LABEL_COUNT;
    localparam int ADDR_BITS   = 2 * LABEL_BITS;
    localparam int POS_BITS    = $clog2(LABEL_COUNT + 1);
    localparam int COUNT_BITS  = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic                  row_ok;
        logic                  col_ok;
        logic [LABEL_BITS-1:0] row_label;
        logic [LABEL_BITS-1:0] col_label;
        logic [POS_BITS-1:0]   total;
    } cmc_order_t;

endpackage

@@ rtl/cmc_class_order.sv @@
// Maps row and column positions in class order to labels and counts the classes seen.
module cmc_class_order
    import cmc_pkg::*;
(
    input  logic [LABEL_COUNT-1:0] true_seen,
    input  logic [LABEL_COUNT-1:0] pred_seen,
    input  logic [3:0]             row_pos,
    input  logic [3:0]             col_pos,
    output cmc_order_t             order
);

    always_comb
    begin
        logic [LABEL_COUNT-1:0] only_pred;
        logic [LABEL_COUNT-1:0] below;
        logic [POS_BITS-1:0]    true_num;
        logic [POS_BITS-1:0]    pos_true;
        logic [POS_BITS-1:0]    pos_pred;
        logic                   row_hit;
        logic                   col_hit;

        only_pred   = pred_seen & ~true_seen;
        true_num    = POS_BITS'($countones(true_seen));
        order       = '0;
        order.total = POS_BITS'($countones(true_seen | pred_seen));
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            // True labels come first, then labels seen only as predictions.
            below    = ~({LABEL_COUNT{1'b1}} << i);
            pos_true = POS_BITS'($countones(true_seen & below));
            pos_pred = true_num + POS_BITS'($countones(only_pred & below));
            row_hit  = (true_seen[i] && (pos_true == POS_BITS'(row_pos)))
                    || (only_pred[i] && (pos_pred == POS_BITS'(row_pos)));
            col_hit  = (true_seen[i] && (pos_true == POS_BITS'(col_pos)))
                    || (only_pred[i] && (pos_pred == POS_BITS'(col_pos)));
            if (row_hit)
            begin
                order.row_ok    = 1'b1;
                order.row_label = LABEL_BITS'(i);
            end
            if (col_hit)
            begin
                order.col_ok    = 1'b1;
                order.col_label = LABEL_BITS'(i);
            end
        end
    end

endmodule

@@ rtl/confusion_matrix_counter.sv @@
// Confusion matrix counter: top level with pair count memory and item pipeline.
// Each item passes through stage one, stage two and the output register.
// Throughput: one item per cycle while the output is not stalled; the count memory is read in
// stage one and written back in stage two, with a bypass for back-to-back updates of one pair.
// Reset clears all counts and marks at once through per-entry valid bits;
// the block takes items as soon as reset is released.
module confusion_matrix_counter
    import cmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic [3:0]            true_label,
    input  logic [3:0]            pred_label,
    input  logic [3:0]            row_index,
    input  logic [3:0]            col_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COUNT_BITS-1:0] cell_count,
    output logic [4:0]            class_total,
    output logic [3:0]            row_class,
    output logic [3:0]            col_class,
    output logic                  in_range,
    output logic                  label_error
);

    logic                  adv_out;
    logic                  adv2;
    logic                  adv1;
    logic                  s1_move;

    logic                  s1_valid_reg;
    action_t               s1_action_reg;
    logic [3:0]            s1_true_reg;
    logic [3:0]            s1_pred_reg;
    logic [3:0]            s1_row_reg;
    logic [3:0]            s1_col_reg;

    logic [LABEL_COUNT-1:0] true_seen_reg;
    logic [LABEL_COUNT-1:0] true_seen_next;
    logic [LABEL_COUNT-1:0] pred_seen_reg;
    logic [LABEL_COUNT-1:0] pred_seen_next;

    logic [COUNT_BITS-1:0] count_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] cell_valid_reg;

    cmc_order_t            order;
    logic                  s1_label_ok;
    logic                  s1_rec_ok;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  rd_en;
    logic                  byp;

    logic                  s2_write_next;
    logic                  s2_inr_next;
    logic                  s2_err_next;
    logic [3:0]            s2_rcls_next;
    logic [3:0]            s2_ccls_next;

    logic                  s2_valid_reg;
    logic                  s2_write_reg;
    logic [ADDR_BITS-1:0]  s2_addr_reg;
    logic                  s2_inr_reg;
    logic                  s2_err_reg;
    logic [3:0]            s2_rcls_reg;
    logic [3:0]            s2_ccls_reg;
    logic [POS_BITS-1:0]   s2_total_reg;
    logic                  s2_hit_reg;
    logic                  s2_byp_reg;
    logic [COUNT_BITS-1:0] s2_byp_data_reg;
    logic [COUNT_BITS-1:0] s2_rd_data_reg;
    logic [COUNT_BITS-1:0] s2_cur;
    logic [COUNT_BITS-1:0] s2_sum;
    logic                  s2_wr_en;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] out_cell_reg;
    logic [POS_BITS-1:0]   out_total_reg;
    logic [3:0]            out_rcls_reg;
    logic [3:0]            out_ccls_reg;
    logic                  out_inr_reg;
    logic                  out_err_reg;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv2     = !s2_valid_reg || adv_out;
    assign adv1     = !s1_valid_reg || adv2;
    assign s1_move  = s1_valid_reg && adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            true_seen_reg <= '0;
            pred_seen_reg <= '0;
        end
        else
        begin
            true_seen_reg <= true_seen_next;
            pred_seen_reg <= pred_seen_next;
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_action_reg <= action_t'(action);
            s1_true_reg   <= true_label;
            s1_pred_reg   <= pred_label;
            s1_row_reg    <= row_index;
            s1_col_reg    <= col_index;
        end
    end

    assign s1_label_ok = (32'(s1_true_reg) < LABEL_COUNT) && (32'(s1_pred_reg) < LABEL_COUNT);
    assign s1_rec_ok   = (s1_action_reg == ACT_RECORD) && s1_label_ok;

    always_comb
    begin
        true_seen_next = true_seen_reg;
        pred_seen_next = pred_seen_reg;
        if (s1_move)
        begin
            case (s1_action_reg)
                ACT_RECORD:
                begin
                    if (s1_label_ok)
                    begin
                        true_seen_next[s1_true_reg[LABEL_BITS-1:0]] = 1'b1;
                        pred_seen_next[s1_pred_reg[LABEL_BITS-1:0]] = 1'b1;
                    end
                end
                ACT_CLEAR:
                begin
                    true_seen_next = '0;
                    pred_seen_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    cmc_class_order u_order (
        .true_seen (true_seen_next),
        .pred_seen (pred_seen_next),
        .row_pos   (s1_row_reg),
        .col_pos   (s1_col_reg),
        .order     (order)
    );

    always_comb
    begin
        s2_write_next = 1'b0;
        s2_inr_next   = 1'b0;
        s2_err_next   = 1'b0;
        s2_rcls_next  = '0;
        s2_ccls_next  = '0;
        case (s1_action_reg)
            ACT_RECORD:
            begin
                s2_write_next = s1_label_ok;
                s2_err_next   = !s1_label_ok;
            end
            ACT_READ:
            begin
                s2_rcls_next = 4'(order.row_label);
                s2_ccls_next = 4'(order.col_label);
                s2_inr_next  = order.row_ok && order.col_ok;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr = (s1_action_reg == ACT_RECORD)
                   ? {s1_true_reg[LABEL_BITS-1:0], s1_pred_reg[LABEL_BITS-1:0]}
                   : {order.row_label, order.col_label};
    assign rd_en   = s1_move && (s1_rec_ok || s2_inr_next);

    assign s2_cur   = s2_byp_reg ? s2_byp_data_reg
                    : (s2_hit_reg ? s2_rd_data_reg : '0);
    assign s2_sum   = (s2_cur == COUNT_MAX) ? s2_cur : s2_cur + 1'b1;
    assign s2_wr_en = s2_valid_reg && adv_out && s2_write_reg;
    assign byp      = s2_wr_en && (s2_addr_reg == rd_addr);

    always_ff @(posedge clk)
    begin
        if (s2_wr_en)
        begin
            count_mem[s2_addr_reg] <= s2_sum;
        end
        if (rd_en)
        begin
            s2_rd_data_reg <= count_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= '0;
        end
        else if (s1_move && (s1_action_reg == ACT_CLEAR))
        begin
            cell_valid_reg <= '0;
        end
        else if (s2_wr_en)
        begin
            cell_valid_reg[s2_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_write_reg    <= s2_write_next;
            s2_addr_reg     <= rd_addr;
            s2_inr_reg      <= s2_inr_next;
            s2_err_reg      <= s2_err_next;
            s2_rcls_reg     <= s2_rcls_next;
            s2_ccls_reg     <= s2_ccls_next;
            s2_total_reg    <= order.total;
            s2_hit_reg      <= cell_valid_reg[rd_addr];
            s2_byp_reg      <= byp;
            s2_byp_data_reg <= s2_sum;
        end
        if (adv_out)
        begin
            out_cell_reg  <= s2_inr_reg ? s2_cur : '0;
            out_total_reg <= s2_total_reg;
            out_rcls_reg  <= s2_rcls_reg;
            out_ccls_reg  <= s2_ccls_reg;
            out_inr_reg   <= s2_inr_reg;
            out_err_reg   <= s2_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_count  = out_cell_reg;
    assign class_total = 5'(out_total_reg);
    assign row_class   = out_rcls_reg;
    assign col_class   = out_ccls_reg;
    assign in_range    = out_inr_reg;
    assign label_error = out_err_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && s2_valid_reg && s1_valid_reg))
        else $error("input stalled while the pipeline has room");

    a_clear_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && (s1_action_reg == ACT_CLEAR))
            |=> ((true_seen_reg == '0) && (pred_seen_reg == '0) && (cell_valid_reg == '0)))
        else $error("clear left marks or counts behind");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg)
            |-> (!out_inr_reg && (out_cell_reg == '0) && (out_rcls_reg == '0)))
        else $error("rejected sample carries matrix data");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(out_total_reg) <= LABEL_COUNT))
        else $error("class total exceeds label count");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the confusion matrix counter, with its own count table model.
`timescale 1ns / 1ps

module testbench;
    import cmc_pkg::*;

    localparam int RANDOM_ITEMS   = 1860;
    localparam int PHASE_LEN      = (RANDOM_ITEMS + 3) / 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic [1:0] {
        PH_FREE       = 2'd0,
        PH_SEND_IDLE  = 2'd1,
        PH_RECV_STALL = 2'd2,
        PH_BOTH       = 2'd3
    } idle_phase_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] cnt;
        logic [4:0]            total;
        logic [3:0]            rcls;
        logic [3:0]            ccls;
        logic                  inr;
        logic                  err;
    } matrix_result_t;

    typedef struct {
        action_t        act;
        logic [3:0]     t;
        logic [3:0]     p;
        logic [3:0]     r;
        logic [3:0]     c;
        int             reps;
        bit             sweep;
        bit             typed;
        matrix_result_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            action;
    logic [3:0]            true_label;
    logic [3:0]            pred_label;
    logic [3:0]            row_index;
    logic [3:0]            col_index;
    logic                  out_valid;
    logic                  out_stall;
    logic [COUNT_BITS-1:0] cell_count;
    logic [4:0]            class_total;
    logic [3:0]            row_class;
    logic [3:0]            col_class;
    logic                  in_range;
    logic                  label_error;

    idle_phase_t           phase_r = PH_FREE;

    logic [COUNT_BITS-1:0] model_counts [CELL_COUNT];
    logic [LABEL_COUNT-1:0] model_true_seen;
    logic [LABEL_COUNT-1:0] model_pred_seen;

    matrix_result_t        pending_results [$];
    stim_row_t             directed [$];

    int fail_count     = 0;
    int results_seen   = 0;
    int records_sent   = 0;
    int reads_sent     = 0;
    int read_hits      = 0;
    int clears_sent    = 0;
    int noops_sent     = 0;
    int max_total      = 0;

    confusion_matrix_counter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .true_label  (true_label),
        .pred_label  (pred_label),
        .row_index   (row_index),
        .col_index   (col_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_count  (cell_count),
        .class_total (class_total),
        .row_class   (row_class),
        .col_class   (col_class),
        .in_range    (in_range),
        .label_error (label_error)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int send_idle_pct(input idle_phase_t ph);
        case (ph)
            PH_SEND_IDLE: return 62;
            PH_BOTH:      return 22;
            default:      return 0;
        endcase
    endfunction

    function automatic int stall_pct(input idle_phase_t ph);
        case (ph)
            PH_RECV_STALL: return 62;
            PH_BOTH:       return 22;
            default:       return 0;
        endcase
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            model_counts[i] = '0;
        end
        model_true_seen = '0;
        model_pred_seen = '0;
    endfunction

    // Class order: labels seen as true ascending, then labels seen only as predicted.
    function automatic bit class_at(input logic [3:0] pos, output logic [3:0] label);
        int k;
        k = 0;
        label = '0;
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            if (model_true_seen[i])
            begin
                if (k == pos)
                begin
                    label = i[3:0];
                    return 1'b1;
                end
                k++;
            end
        end
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            if (model_pred_seen[i] && !model_true_seen[i])
            begin
                if (k == pos)
                begin
                    label = i[3:0];
                    return 1'b1;
                end
                k++;
            end
        end
        return 1'b0;
    endfunction

    function automatic matrix_result_t confusion_step(input action_t act,
                                                      input logic [3:0] t, p, r, c);
        matrix_result_t res;
        logic [3:0]     rl;
        logic [3:0]     cl;
        bit             rok;
        bit             cok;
        int             idx;
        int             seen;
        res = '0;
        case (act)
            ACT_RECORD:
            begin
                if (t >= LABEL_COUNT || p >= LABEL_COUNT)
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    idx = t * LABEL_COUNT + p;
                    if (model_counts[idx] != COUNT_MAX)
                    begin
                        model_counts[idx] = model_counts[idx] + 1'b1;
                    end
                    model_true_seen[t] = 1'b1;
                    model_pred_seen[p] = 1'b1;
                end
            end
            ACT_READ:
            begin
                rok = class_at(r, rl);
                cok = class_at(c, cl);
                if (rok)
                begin
                    res.rcls = rl;
                end
                if (cok)
                begin
                    res.ccls = cl;
                end
                if (rok && cok)
                begin
                    res.cnt = model_counts[rl * LABEL_COUNT + cl];
                    res.inr = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                clear_model();
            end
            default:
            begin
            end
        endcase
        seen = $countones(model_true_seen | model_pred_seen);
        res.total = (seen > 31) ? 5'd31 : seen[4:0];
        return res;
    endfunction

    function automatic matrix_result_t result_of(input int cnt, total, rcls, ccls,
                                                 input bit inr, err);
        matrix_result_t res;
        res.cnt   = cnt[COUNT_BITS-1:0];
        res.total = total[4:0];
        res.rcls  = rcls[3:0];
        res.ccls  = ccls[3:0];
        res.inr   = inr;
        res.err   = err;
        return res;
    endfunction

    function automatic stim_row_t typed_row(input action_t act, input int t, p, r, c,
                                            input matrix_result_t want);
        stim_row_t s;
        s.act   = act;
        s.t     = t[3:0];
        s.p     = p[3:0];
        s.r     = r[3:0];
        s.c     = c[3:0];
        s.reps  = 1;
        s.sweep = 1'b0;
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic stim_row_t pred_row(input action_t act, input int t, p, r, c,
                                           input int reps, input bit sweep);
        stim_row_t s;
        s.act   = act;
        s.t     = t[3:0];
        s.p     = p[3:0];
        s.r     = r[3:0];
        s.c     = c[3:0];
        s.reps  = reps;
        s.sweep = sweep;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    task automatic send_item(input action_t act, input logic [3:0] t, p, r, c,
                             input bit typed, input matrix_result_t want);
        matrix_result_t predicted;
        while ($urandom_range(99) < send_idle_pct(phase_r))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        true_label <= t;
        pred_label <= p;
        row_index  <= r;
        col_index  <= c;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        predicted = confusion_step(act, t, p, r, c);
        pending_results.push_back(typed ? want : predicted);
        if (predicted.total > max_total)
        begin
            max_total = predicted.total;
        end
        case (act)
            ACT_RECORD: records_sent++;
            ACT_READ:
            begin
                reads_sent++;
                if (predicted.inr)
                begin
                    read_hits++;
                end
            end
            ACT_CLEAR:  clears_sent++;
            default:    noops_sent++;
        endcase
    endtask

    always @(posedge clk)
    begin : result_check
        matrix_result_t want;
        matrix_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.cnt   = cell_count;
            got.total = class_total;
            got.rcls  = row_class;
            got.ccls  = col_class;
            got.inr   = in_range;
            got.err   = label_error;
            if (pending_results.size() == 0)
            begin
                if (fail_count < REPORT_LIMIT)
                begin
                    $display("unexpected result:");
                    $display("  got cell=%0d total=%0d row=%0d col=%0d rng=%0b err=%0b",
                             got.cnt, got.total, got.rcls, got.ccls, got.inr, got.err);
                end
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cnt !== want.cnt || got.total !== want.total ||
                    got.rcls !== want.rcls || got.ccls !== want.ccls ||
                    got.inr !== want.inr || got.err !== want.err)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("result %0d mismatch:", results_seen);
                        $display("  want cell=%0d total=%0d row=%0d col=%0d rng=%0b err=%0b",
                                 want.cnt, want.total, want.rcls, want.ccls,
                                 want.inr, want.err);
                        $display("  got  cell=%0d total=%0d row=%0d col=%0d rng=%0b err=%0b",
                                 got.cnt, got.total, got.rcls, got.ccls, got.inr, got.err);
                    end
                    fail_count++;
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int held_for;
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_r == PH_RECV_STALL && !hold_done)
            begin
                // A long hold-off so the pipeline fills and the input side stalls.
                hold_done = 1'b1;
                held_for  = 0;
                while (held_for < HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    held_for++;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct(phase_r));
        end
    end

    initial
    begin : stimulus
        logic [3:0]     step;
        action_t        act;
        logic [3:0]     t;
        logic [3:0]     p;
        logic [3:0]     r;
        logic [3:0]     c;
        int             pick;
        int             total_now;
        int             true_base;
        int             true_span;
        int             pred_base;
        int             pred_span;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_RECORD;
        true_label = '0;
        pred_label = '0;
        row_index  = '0;
        col_index  = '0;
        clear_model();

        directed.push_back(typed_row(ACT_READ, 0, 0, 0, 0, result_of(0, 0, 0, 0, 0, 0)));
        directed.push_back(typed_row(ACT_NONE, 15, 15, 15, 15, result_of(0, 0, 0, 0, 0, 0)));
        directed.push_back(typed_row(ACT_RECORD, 15, 0, 0, 0, result_of(0, 2, 0, 0, 0, 0)));
        directed.push_back(typed_row(ACT_RECORD, 0, 15, 15, 15, result_of(0, 2, 0, 0, 0, 0)));
        directed.push_back(typed_row(ACT_RECORD, 15, 15, 0, 0, result_of(0, 2, 0, 0, 0, 0)));
        directed.push_back(pred_row(ACT_READ, 0, 0, 0, 0, 1, 1'b0));
        directed.push_back(pred_row(ACT_READ, 0, 0, 1, 1, 1, 1'b0));
        directed.push_back(pred_row(ACT_READ, 0, 0, 0, 1, 1, 1'b0));
        directed.push_back(pred_row(ACT_READ, 0, 0, 1, 0, 1, 1'b0));
        directed.push_back(typed_row(ACT_READ, 0, 0, 15, 15, result_of(0, 2, 0, 0, 0, 0)));
        directed.push_back(pred_row(ACT_READ, 0, 0, 1, 2, 1, 1'b0));
        directed.push_back(pred_row(ACT_READ, 0, 0, 2, 0, 1, 1'b0));
        directed.push_back(pred_row(ACT_RECORD, 3, 7, 0, 0, 1, 1'b0));
        directed.push_back(pred_row(ACT_READ, 0, 0, 3, 3, 1, 1'b0));
        directed.push_back(pred_row(ACT_READ, 0, 0, 1, 3, 1, 1'b0));
        directed.push_back(pred_row(ACT_NONE, 0, 0, 0, 0, 1, 1'b0));
        directed.push_back(typed_row(ACT_CLEAR, 15, 15, 15, 15, result_of(0, 0, 0, 0, 0, 0)));
        directed.push_back(typed_row(ACT_READ, 0, 0, 0, 0, result_of(0, 0, 0, 0, 0, 0)));
        directed.push_back(pred_row(ACT_RECORD, 5, 9, 0, 0, 40, 1'b0));
        directed.push_back(typed_row(ACT_READ, 0, 0, 0, 1, result_of(40, 2, 5, 9, 1, 0)));
        directed.push_back(pred_row(ACT_READ, 0, 0, 1, 0, 1, 1'b0));
        directed.push_back(pred_row(ACT_RECORD, 0, 1, 0, 0, 16, 1'b1));
        directed.push_back(pred_row(ACT_READ, 0, 0, 0, 15, 16, 1'b1));
        directed.push_back(pred_row(ACT_READ, 0, 0, 15, 15, 1, 1'b0));
        directed.push_back(typed_row(ACT_CLEAR, 0, 0, 0, 0, result_of(0, 0, 0, 0, 0, 0)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            for (int k = 0; k < directed[i].reps; k++)
            begin
                step = directed[i].sweep ? k[3:0] : 4'd0;
                send_item(directed[i].act, directed[i].t + step, directed[i].p + step,
                          directed[i].r + step, directed[i].c + step,
                          directed[i].typed, directed[i].want);
            end
        end

        true_base = $urandom_range(15);
        true_span = $urandom_range(1, 16);
        pred_base = $urandom_range(15);
        pred_span = $urandom_range(1, 16);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                case (n / PHASE_LEN)
                    0:       phase_r <= PH_FREE;
                    1:       phase_r <= PH_SEND_IDLE;
                    2:       phase_r <= PH_RECV_STALL;
                    default: phase_r <= PH_BOTH;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 58)
            begin
                act = ACT_RECORD;
            end
            else if (pick < 92)
            begin
                act = ACT_READ;
            end
            else if (pick < 96)
            begin
                act = ACT_CLEAR;
            end
            else
            begin
                act = ACT_NONE;
            end
            total_now = $countones(model_true_seen | model_pred_seen);
            t = 4'((true_base + $urandom_range(true_span - 1)) % 16);
            p = 4'((pred_base + $urandom_range(pred_span - 1)) % 16);
            if (total_now > 0 && $urandom_range(9) < 8)
            begin
                r = 4'($urandom_range(total_now - 1));
            end
            else
            begin
                r = 4'($urandom_range(15));
            end
            if (total_now > 0 && $urandom_range(9) < 8)
            begin
                c = 4'($urandom_range(total_now - 1));
            end
            else
            begin
                c = 4'($urandom_range(15));
            end
            send_item(act, t, p, r, c, 1'b0, '0);
            if (act == ACT_CLEAR)
            begin
                true_base = $urandom_range(15);
                true_span = $urandom_range(1, 16);
                pred_base = $urandom_range(15);
                pred_span = $urandom_range(1, 16);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d records, %0d reads (%0d in range), %0d clears, %0d no-ops.",
                 records_sent, reads_sent, read_hits, clears_sent, noops_sent);
        $display("Checked %0d results; largest class total %0d; one pair counted many times.",
                 results_seen, max_total);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
